[design/etns_pkg.sv]
package etns_pkg;

    localparam int NODE_W = 16;
    localparam int IDX_W  = 5;
    localparam int REL_W  = 2;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef struct packed {
        logic              op;
        logic [IDX_W-1:0]  entry_index;
        logic [NODE_W-1:0] entry_src;
        logic [NODE_W-1:0] entry_dst;
        logic [REL_W-1:0]  entry_rel;
        logic [NODE_W-1:0] key_node;
        logic [REL_W-1:0]  key_rel;
        logic              parent_search;
    } etns_in_t;

    typedef struct packed {
        logic [NODE_W-1:0] match_node;
        logic              end_of_search;
    } etns_out_t;

    // controller -> datapath
    typedef struct packed {
        logic wr_en;
        logic load_key;
        logic rd_en;
        logic advance;
        logic load_hit;
        logic load_end;
    } etns_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic all_issued;
        logic data_valid;
        logic hit;
        logic out_free;
    } etns_sts_t;

endpackage

[design/etns_dpath.sv]
module etns_dpath
    import etns_pkg::*;
#(
    parameter int TABLE_DEPTH = 32,
    parameter int NODE_WIDTH  = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  etns_in_t  s_data,
    input  logic      m_ready,
    input  etns_cmd_t cmd,
    output etns_sts_t sts,
    output logic      m_valid,
    output etns_out_t m_data
);

    localparam int SW = (NODE_WIDTH < NODE_W) ? NODE_WIDTH : NODE_W;
    localparam int EW = 2 * SW + REL_W;
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [EW-1:0]    mem [TABLE_DEPTH];
    logic [EW-1:0]    rdata_reg;
    logic             data_valid_reg;
    logic [CW-1:0]    addr_reg;
    logic [SW-1:0]    key_reg;
    logic [REL_W-1:0] key_rel_reg;
    logic             parent_reg;
    logic             out_valid_reg;
    etns_out_t        out_reg;

    logic [SW-1:0]    rd_src;
    logic [SW-1:0]    rd_dst;
    logic [REL_W-1:0] rd_rel;
    logic [SW-1:0]    probe;
    logic [SW-1:0]    other;
    logic             in_range;

    assign in_range = 32'(s_data.entry_index) < TABLE_DEPTH;

    // table storage: written from the input port, scanned one entry per read
    always_ff @(posedge aclk) begin
        if (cmd.wr_en && in_range) begin
            mem[IW'(s_data.entry_index)] <= {SW'(s_data.entry_src), SW'(s_data.entry_dst),
                                             s_data.entry_rel};
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem[addr_reg[IW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_key) begin
            key_reg     <= SW'(s_data.key_node);
            key_rel_reg <= s_data.key_rel;
            parent_reg  <= s_data.parent_search;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg       <= '0;
            data_valid_reg <= 1'b0;
        end else if (cmd.load_key) begin
            addr_reg       <= '0;
            data_valid_reg <= 1'b0;
        end else begin
            if (cmd.rd_en) begin
                addr_reg <= addr_reg + CW'(1);
            end
            if (cmd.advance) begin
                data_valid_reg <= cmd.rd_en;
            end
        end
    end

    assign {rd_src, rd_dst, rd_rel} = rdata_reg;
    assign probe = parent_reg ? rd_dst : rd_src;
    assign other = parent_reg ? rd_src : rd_dst;

    assign sts.hit        = (probe == key_reg) && (rd_rel == key_rel_reg);
    assign sts.data_valid = data_valid_reg;
    assign sts.all_issued = (addr_reg == CW'(TABLE_DEPTH));
    assign sts.out_free   = !out_valid_reg || m_ready;

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_hit || cmd.load_end) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_hit) begin
            out_reg.match_node    <= NODE_W'(other);
            out_reg.end_of_search <= 1'b0;
        end else if (cmd.load_end) begin
            out_reg.match_node    <= '0;
            out_reg.end_of_search <= 1'b1;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_no_read_past_end: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_en |-> (addr_reg < CW'(TABLE_DEPTH)))
        else $error("read issued past last table entry");

    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !(cmd.load_hit || cmd.load_end))
        else $error("pending result overwritten");

    a_write_only_when_idle_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_en |-> !(cmd.rd_en || data_valid_reg))
        else $error("table write during scan");

endmodule

[design/etns_ctrl.sv]
module etns_ctrl
    import etns_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_op,
    output logic      s_ready,
    input  etns_sts_t sts,
    output etns_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_END  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       stall;

    // a matching entry waits while the result register is still occupied
    assign stall = sts.data_valid && sts.hit && !sts.out_free;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_op == OP_SEARCH) begin
                        cmd.load_key = 1'b1;
                        state_next   = ST_SCAN;
                    end else begin
                        cmd.wr_en = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                if (!stall) begin
                    cmd.advance  = 1'b1;
                    cmd.rd_en    = !sts.all_issued;
                    cmd.load_hit = sts.data_valid && sts.hit;
                    if (sts.all_issued) begin
                        state_next = ST_END;
                    end
                end
            end
            ST_END: begin
                if (sts.out_free) begin
                    cmd.load_end = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_stall_holds_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && stall) |=> (state_reg == ST_SCAN))
        else $error("scan left while a match was pending");

    a_single_load: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.load_hit && cmd.load_end))
        else $error("hit and end loaded together");

    a_end_after_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_end |-> !sts.data_valid)
        else $error("end item issued with an unchecked entry");

endmodule

[design/edge_table_neighbour_search.sv]
// Write transfer: accepted while idle, no result.
// Search transfer: the scan reads one table entry per cycle through a single memory
// read port, except that it holds while a match is pending and m_ready stays low; the
// end item follows once every entry is checked and the output is free.
// Reset (aresetn, synchronous, active low) clears control and output valid only;
// table contents are undefined until written.
module edge_table_neighbour_search
    import etns_pkg::*;
#(
    parameter int TABLE_DEPTH = 32,
    parameter int NODE_WIDTH  = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    // input channel
    input  logic      s_valid,
    output logic      s_ready,
    input  etns_in_t  s_data,
    // result channel
    output logic      m_valid,
    input  logic      m_ready,
    output etns_out_t m_data
);

    // Command and status between the sequencer and the table datapath.
    etns_cmd_t cmd;
    etns_sts_t sts;

    // Sequencer: idle / scan / end. Takes a transfer only when idle; a write
    // goes straight into the table, a search latches its key and starts the scan.
    // During the scan it steps the read address, hands matches to the result
    // register and pauses on a match while that register is still full.
    etns_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_data.op),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Datapath: edge table memory, registered read, key compare and the
    // output register. The output register is separate from the scan, so a
    // new transfer is taken while the end item is still waiting on m_ready.
    etns_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .NODE_WIDTH  (NODE_WIDTH)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

endmodule

[test/edge_table_neighbour_search_tb.sv]
`timescale 1ns / 1ps

module edge_table_neighbour_search_tb;
    import etns_pkg::*;

    localparam int TABLE_DEPTH     = 32;
    localparam int NODE_WIDTH      = 16;
    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 6;
    localparam int ITEMS_PER_PHASE = 22;
    // Consecutive cycles without any transfer before the run is declared hung.
    localparam int STALL_LIMIT     = 5000;
    // Margin after the last predicted result, to catch stray results.
    localparam int TAIL_CYCLES     = TABLE_DEPTH + 8;

    // Shadow of the edge table plus the queue of neighbours still owed by the block.
    class search_scoreboard;
        logic [NODE_W-1:0] edge_src [TABLE_DEPTH];
        logic [NODE_W-1:0] edge_dst [TABLE_DEPTH];
        logic [REL_W-1:0]  edge_rel [TABLE_DEPTH];
        etns_out_t         expected_hits[$];
        int                mismatches;

        // Called for every accepted input transfer.
        function void note_input(etns_in_t item);
            etns_out_t hit;
            logic [NODE_W-1:0] probe;
            if (item.op == OP_WRITE) begin
                // Writes past the table end are dropped.
                if (item.entry_index < TABLE_DEPTH) begin
                    edge_src[item.entry_index] = item.entry_src;
                    edge_dst[item.entry_index] = item.entry_dst;
                    edge_rel[item.entry_index] = item.entry_rel;
                end
                return;
            end
            // Search: scan in slot order, parent mode keys on dst and returns src.
            for (int k = 0; k < TABLE_DEPTH; k++) begin
                probe = item.parent_search ? edge_dst[k] : edge_src[k];
                if (probe == item.key_node && edge_rel[k] == item.key_rel) begin
                    hit.match_node    = item.parent_search ? edge_src[k] : edge_dst[k];
                    hit.end_of_search = 1'b0;
                    expected_hits.push_back(hit);
                end
            end
            hit.match_node    = '0;
            hit.end_of_search = 1'b1;
            expected_hits.push_back(hit);
        endfunction

        // Called for every accepted result transfer.
        function void check_result(etns_out_t got);
            etns_out_t want;
            if (expected_hits.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual match_node=%h end=%b",
                         $time, got.match_node, got.end_of_search);
                mismatches++;
                return;
            end
            want = expected_hits.pop_front();
            if (got.match_node !== want.match_node) begin
                $display("%0t: match_node mismatch: expected %h, actual %h",
                         $time, want.match_node, got.match_node);
                mismatches++;
            end
            if (got.end_of_search !== want.end_of_search) begin
                $display("%0t: end_of_search mismatch: expected %b, actual %b",
                         $time, want.end_of_search, got.end_of_search);
                mismatches++;
            end
        endfunction
    endclass

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    etns_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    etns_out_t m_data;

    // Percent of cycles the sender sits idle / the receiver holds off.
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int quiet_cycles  = 0;

    search_scoreboard sb;

    edge_table_neighbour_search #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .NODE_WIDTH (NODE_WIDTH)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Receiver backpressure, redrawn every cycle.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Monitor: both channels sampled at the edge where the transfer happens.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_input(s_data);
            end
            if (m_valid && m_ready) begin
                sb.check_result(m_data);
            end
        end
    end

    // Watchdog: any transfer on either channel counts as progress.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("%0t: timeout, no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Fully random input word; callers overwrite the fields that matter.
    function automatic etns_in_t noise_item();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return etns_in_t'(raw[$bits(etns_in_t)-1:0]);
    endfunction

    // Mostly a small pool of node ids so searches actually hit; sometimes anything.
    function automatic logic [NODE_W-1:0] pick_node();
        logic [NODE_W-1:0] pool [6];
        pool = '{16'h0000, 16'h0001, 16'hFFFF, 16'h5A5A, 16'hA5A5, 16'h8000};
        if ($urandom_range(99) < 80) begin
            return pool[$urandom_range(5)];
        end
        return NODE_W'($urandom);
    endfunction

    // One input transfer; valid stays up until the block takes it.
    task automatic send_item(input etns_in_t item);
        bit taken;
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end while (!taken);
    endtask

    task automatic write_edge(input int slot, input logic [NODE_W-1:0] src,
                              input logic [NODE_W-1:0] dst, input logic [REL_W-1:0] rel);
        etns_in_t item;
        item             = noise_item();
        item.op          = OP_WRITE;
        item.entry_index = IDX_W'(slot);
        item.entry_src   = src;
        item.entry_dst   = dst;
        item.entry_rel   = rel;
        send_item(item);
    endtask

    task automatic search_for(input logic [NODE_W-1:0] key, input logic [REL_W-1:0] rel,
                              input logic parent);
        etns_in_t item;
        item               = noise_item();
        item.op            = OP_SEARCH;
        item.key_node      = key;
        item.key_rel       = rel;
        item.parent_search = parent;
        send_item(item);
    endtask

    // Random mix of writes and searches under one idle/stall profile.
    task automatic run_phase(input int idle_pct, input int stall_pct);
        etns_in_t item;
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
        repeat (ITEMS_PER_PHASE) begin
            item = noise_item();
            if ($urandom_range(99) < 35) begin
                item.op        = OP_WRITE;
                item.entry_src = pick_node();
                item.entry_dst = pick_node();
            end else begin
                item.op       = OP_SEARCH;
                item.key_node = pick_node();
            end
            send_item(item);
        end
    endtask

    initial begin
        sb = new;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Full table load first: no search may touch an unwritten slot.
        // Every slot leaves node 00A5 on relation 2, so one search returns all of them.
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            write_edge(k, 16'h00A5,
                       (k == 0) ? 16'h0000 :
                       (k == TABLE_DEPTH - 1) ? 16'hFFFF : NODE_W'(k * 16'h0843),
                       2'd2);
        end
        search_for(16'h00A5, 2'd2, 1'b0);   // every slot matches
        search_for(16'hFFFF, 2'd2, 1'b1);   // parent of the top slot
        search_for(16'h00A5, 2'd1, 1'b0);   // node matches, relation does not
        search_for(16'h00A5, 2'd2, 1'b1);   // wrong direction, end only

        // Extreme entries at both ends of the table, slot 31 rewritten.
        write_edge(0, 16'hFFFF, 16'h0000, 2'd3);
        write_edge(TABLE_DEPTH - 1, 16'h0000, 16'hFFFF, 2'd0);
        write_edge(TABLE_DEPTH - 1, 16'hFFFF, 16'h0000, 2'd3);
        write_edge(15, 16'h0000, 16'hFFFF, 2'd0);
        search_for(16'hFFFF, 2'd3, 1'b0);
        search_for(16'h0000, 2'd3, 1'b1);
        search_for(16'h0000, 2'd0, 1'b0);
        search_for(16'hFFFF, 2'd0, 1'b1);
        search_for(16'h00A5, 2'd2, 1'b0);

        run_phase(0, 0);
        run_phase(77, 0);
        run_phase(0, 77);
        run_phase(31, 31);

        s_valid       <= 1'b0;
        snk_stall_pct  = 0;
        // Let the monitor log the last input transfer before the queue is inspected.
        @(posedge aclk);
        while (sb.expected_hits.size() != 0) @(posedge aclk);
        // Catch any result the block emits beyond what was predicted.
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (sb.mismatches == 0 && sb.expected_hits.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[edge_table_neighbour_search.f]
design/etns_pkg.sv
design/etns_dpath.sv
design/etns_ctrl.sv
design/edge_table_neighbour_search.sv
test/edge_table_neighbour_search_tb.sv
